// ===== rtl/fdd_pkg.sv =====
// Shared types and constants for the finite difference derivative block.
// Holds the item, result and queued-operation structs and the register map.
// No dependencies; every other file in rtl/ imports this package.
package fdd_pkg;

  localparam int SAMPLE_WIDTH = 24;
  // Worst case difference is 3*x - 4*p1 + p2, which needs three extra bits.
  localparam int DIFF_WIDTH = SAMPLE_WIDTH + 3;
  localparam int SPACING_WIDTH = 24;
  localparam int PROD_WIDTH = DIFF_WIDTH + SPACING_WIDTH + 1;
  localparam int FRAC_BITS = 16;
  localparam int DERIV_WIDTH = 35;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 24;

  localparam logic [SPACING_WIDTH-1:0] INV_SPACING_RESET = SPACING_WIDTH'(65536);
  localparam logic EDGE_ORDER_RESET = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_INV_SPACING = 2'd0,
    CFG_EDGE_ORDER  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           column_end;
  } item_t;

  typedef struct packed {
    logic signed [DERIV_WIDTH-1:0] derivative;
    logic                          last_of_run;
    logic                          column_done;
    logic                          too_short;
  } result_t;

  // One pending derivative: the raw difference and how to scale it.
  typedef struct packed {
    logic signed [DIFF_WIDTH-1:0] diff;
    logic                         double_span;
    logic                         last_of_run;
    logic                         column_done;
    logic                         too_short;
  } diff_op_t;

endpackage

// ===== rtl/fdd_front.sv =====
// Front end: accepts samples, keeps the column history and turns each
// sample into zero to three difference operations for the queue.
// Depends on fdd_pkg.
module fdd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             edge_order_two,
  input  logic             item_valid,
  output logic             item_stall,
  input  fdd_pkg::item_t   item,
  input  logic             q_full,
  output logic             q_push,
  output fdd_pkg::diff_op_t q_data
);
  import fdd_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] prev_one;
  logic signed [SAMPLE_WIDTH-1:0] prev_two;
  logic [1:0]                     seen_count;
  diff_op_t                       pend [2];
  logic [1:0]                     pend_cnt;

  diff_op_t                     ops [3];
  logic [1:0]                   n_ops;
  logic                         accept;
  logic signed [DIFF_WIDTH-1:0] x_e;
  logic signed [DIFF_WIDTH-1:0] p1_e;
  logic signed [DIFF_WIDTH-1:0] p2_e;
  logic signed [DIFF_WIDTH-1:0] d_fwd;
  logic signed [DIFF_WIDTH-1:0] d_back;
  logic signed [DIFF_WIDTH-1:0] d_central;
  logic signed [DIFF_WIDTH-1:0] d_left2;
  logic signed [DIFF_WIDTH-1:0] d_right2;

  // The front holds while it still owes queued operations for the last sample or while the queue is full.
  assign item_stall = (pend_cnt != 2'd0) || q_full;
  assign accept = item_valid && !item_stall;

  always_comb begin
    x_e  = DIFF_WIDTH'(item.sample);
    p1_e = DIFF_WIDTH'(prev_one);
    p2_e = DIFF_WIDTH'(prev_two);
    d_fwd     = p1_e - p2_e;
    d_back    = x_e - p1_e;
    d_central = x_e - p2_e;
    d_left2   = (p1_e <<< 2) - (p2_e <<< 1) - p2_e - x_e;
    d_right2  = (x_e <<< 1) + x_e - (p1_e <<< 2) + p2_e;

    for (int k = 0; k < 3; k++) begin
      ops[k] = '0;
    end
    n_ops = 2'd0;

    unique case (seen_count)
      2'd0: begin
        if (item.column_end) begin
          ops[0].column_done = 1'b1;
          ops[0].too_short = 1'b1;
          n_ops = 2'd1;
        end
      end
      2'd1: begin
        if (item.column_end) begin
          ops[0].diff = d_back;
          ops[1].diff = d_back;
          ops[1].column_done = 1'b1;
          n_ops = 2'd2;
        end
      end
      default: begin
        if (seen_count == 2'd2) begin
          ops[0].diff = edge_order_two ? d_left2 : d_fwd;
          ops[0].double_span = edge_order_two;
          ops[1].diff = d_central;
          ops[1].double_span = 1'b1;
          ops[2].diff = edge_order_two ? d_right2 : d_back;
          ops[2].double_span = edge_order_two;
          ops[2].column_done = 1'b1;
          n_ops = item.column_end ? 2'd3 : 2'd2;
        end else begin
          ops[0].diff = d_central;
          ops[0].double_span = 1'b1;
          ops[1].diff = edge_order_two ? d_right2 : d_back;
          ops[1].double_span = edge_order_two;
          ops[1].column_done = 1'b1;
          n_ops = item.column_end ? 2'd2 : 2'd1;
        end
      end
    endcase

    if (n_ops != 2'd0) begin
      ops[n_ops - 2'd1].last_of_run = 1'b1;
    end
  end

  always_comb begin
    if (accept) begin
      q_push = (n_ops != 2'd0);
      q_data = ops[0];
    end else begin
      q_push = (pend_cnt != 2'd0) && !q_full;
      q_data = pend[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_one <= '0;
      prev_two <= '0;
      seen_count <= 2'd0;
      pend_cnt <= 2'd0;
    end else begin
      if (accept) begin
        if (item.column_end) begin
          prev_one <= '0;
          prev_two <= '0;
          seen_count <= 2'd0;
        end else begin
          prev_two <= prev_one;
          prev_one <= item.sample;
          if (seen_count != 2'd3) begin
            seen_count <= seen_count + 2'd1;
          end
        end
        pend_cnt <= (n_ops == 2'd0) ? 2'd0 : n_ops - 2'd1;
      end else if (q_push) begin
        pend_cnt <= pend_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend[0] <= ops[1];
      pend[1] <= ops[2];
    end else if (q_push) begin
      pend[0] <= pend[1];
    end
  end

endmodule

// ===== rtl/fdd_queue.sv =====
// Small first-in first-out queue of difference operations between the
// front and back ends. Depends on fdd_pkg.
module fdd_queue #(
  parameter int DEPTH = fdd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fdd_pkg::diff_op_t push_data,
  input  logic              pop,
  output fdd_pkg::diff_op_t head,
  output logic              full,
  output logic              empty
);
  import fdd_pkg::*;

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);

  diff_op_t              entries [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   count;

  assign full = (count == CntWidth'(DEPTH));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (push && !pop) begin
        count <= count + CntWidth'(1);
      end else if (pop && !push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/fdd_back.sv =====
// Back end: scales queued differences by the reciprocal spacing, shifts,
// saturates and drives the result register. Depends on fdd_pkg.
module fdd_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [fdd_pkg::SPACING_WIDTH-1:0]     inv_spacing,
  input  fdd_pkg::diff_op_t                     head,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output fdd_pkg::result_t                      result
);
  import fdd_pkg::*;

  logic                         advance;
  logic                         prod_valid;
  logic signed [PROD_WIDTH-1:0] prod;
  logic                         prod_double;
  logic                         prod_last;
  logic                         prod_done;
  logic                         prod_short;

  logic signed [PROD_WIDTH-1:0]     shifted;
  logic [PROD_WIDTH-DERIV_WIDTH:0]  upper;
  logic signed [DERIV_WIDTH-1:0]    deriv_sat;

  // The whole back end moves as one pipeline whenever the result register frees.
  assign advance = !result_valid || !result_stall;
  assign q_pop = advance && !q_empty;

  always_comb begin
    shifted = prod_double ? (prod >>> (FRAC_BITS + 1)) : (prod >>> FRAC_BITS);
    upper = shifted[PROD_WIDTH-1:DERIV_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      deriv_sat = shifted[DERIV_WIDTH-1:0];
    end else if (shifted[PROD_WIDTH-1]) begin
      deriv_sat = {1'b1, {(DERIV_WIDTH-1){1'b0}}};
    end else begin
      deriv_sat = {1'b0, {(DERIV_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= q_pop;
      result_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= head.diff * $signed({1'b0, inv_spacing});
      prod_double <= head.double_span;
      prod_last <= head.last_of_run;
      prod_done <= head.column_done;
      prod_short <= head.too_short;
      result.derivative <= deriv_sat;
      result.last_of_run <= prod_last;
      result.column_done <= prod_done;
      result.too_short <= prod_short;
    end
  end

endmodule

// ===== rtl/finite_difference_derivative.sv =====
// Top level of the streaming finite difference derivative block.
// Depends on fdd_pkg, fdd_front, fdd_queue and fdd_back.
//
// Usage: samples of one grid column arrive on the item channel in index
// order, one beat per sample, with column_end set on the final sample. The
// result channel carries one beat per grid index with the first derivative
// at that index, in index order; a one-sample column yields a single beat
// with too_short set. Each channel moves a beat on a rising edge where valid
// is high and stall is low.
//
// Throughput is one sample per cycle while the queue has room and each sample
// produces at most one result, as every interior sample does. A sample that
// produces two or three results (the column end, the third sample, a
// two-sample column) holds the item channel until all of its operations are
// queued, since the front pushes one operation per cycle into the queue. The
// back end delivers one result per cycle through one multiplier while the
// receiver does not stall.
//
// Configuration: index 0 is inv_spacing (unsigned Q8.16), index 1 is
// edge_order_two. cfg_ready is always high; other indexes are ignored.
// Write registers only while the block is idle.
//
// Reset clears the history, the queue and the result register and restores
// the register defaults. When the receiver stalls, the result register
// holds, the queue fills, and the item channel then stalls in turn.
module finite_difference_derivative #(
  parameter int QUEUE_DEPTH = fdd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  fdd_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output fdd_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fdd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import fdd_pkg::*;

  logic [SPACING_WIDTH-1:0] inv_spacing;
  logic                     edge_order_two;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  diff_op_t q_in;
  diff_op_t q_head;

  // Configuration registers. Writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing <= INV_SPACING_RESET;
      edge_order_two <= EDGE_ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INV_SPACING: inv_spacing <= cfg_data[SPACING_WIDTH-1:0];
        CFG_EDGE_ORDER:  edge_order_two <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front classifies each sample and emits difference operations.
  fdd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .edge_order_two (edge_order_two),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  // The queue lets the front keep taking samples while results wait.
  fdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back end scales each difference and owns the result register.
  fdd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .inv_spacing  (inv_spacing),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // The front must never push into a full queue unless a slot frees that cycle.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_full || q_pop))
    else $error("operation pushed into a full queue");

  // The back end must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("operation popped from an empty queue");

  // An error result always closes its column and its run and carries a zero derivative.
  a_short_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.too_short) |->
      (result.column_done && result.last_of_run && (result.derivative == '0)))
    else $error("malformed too_short result");

  // Leaving reset, the queue starts empty.
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> q_empty)
    else $error("queue not empty after reset");

endmodule
